FILE: rtl/sdrc_pkg.sv
// shared types, constants and defaults for the ship/drrip replacement core
package sdrc_pkg;

	// default geometry
	localparam int unsigned SETS_DEF        = 2048;
	localparam int unsigned WAYS_DEF        = 16;
	localparam int unsigned SIG_ENTRIES_DEF = 4096;

	// item field widths
	localparam int unsigned SET_IN_W  = 11;
	localparam int unsigned WAY_IN_W  = 4;
	localparam int unsigned PC_W      = 64;
	localparam int unsigned S_DATA_W  = 80;
	localparam int unsigned M_DATA_W  = 8;
	localparam int unsigned THR_W     = 3;
	localparam int unsigned SEL_W     = 10;
	localparam int unsigned BIM_W     = 6;
	localparam int unsigned SC_W      = 3;
	localparam int unsigned RRPV_W    = 2;

	// re-reference values
	localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
	localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_HOT  = 2'd0;

	// signature counters
	localparam logic [SC_W-1:0] SIG_TOP   = 3'd7;
	localparam logic [SC_W-1:0] SIG_START = 3'd4;
	localparam logic [SC_W-1:0] SIG_ZERO  = 3'd0;

	// set dueling
	localparam logic [SEL_W-1:0] SEL_TOP   = 10'd1023;
	localparam logic [SEL_W-1:0] SEL_MID   = 10'd511;
	localparam logic [SEL_W-1:0] SEL_ZERO  = 10'd0;
	localparam logic [5:0]       LEAD_SRRIP = 6'd0;
	localparam logic [5:0]       LEAD_BRRIP = 6'd1;

	localparam logic [BIM_W-1:0] BIM_ZERO  = 6'd0;
	localparam logic [THR_W-1:0] THR_RESET = 3'd5;

	// pc hash shifts
	localparam int unsigned HASH_SH1 = 13;
	localparam int unsigned HASH_SH2 = 23;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic fetch;   // capture item and read both memories
		logic commit;  // write back row, counter and training state
		logic clear;   // clearing pass write
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic victim_req;  // item in execute produces a result
	} sts_t;

endpackage

FILE: rtl/ship_drrip_cache_replacement_core.sv
// top level of the ship/drrip last-level cache replacement core
//
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       tuser: operation; tdata: set, way, pc, hit
// m_*       out        m_tvalid / m_tready       tdata: victim way
// cfg_*     in         cfg_valid / cfg_ready     hot threshold
//
// one port on each memory: the accepting edge reads the set row and the signature
//   counter, the commit edge writes the row back and, on an update hit, the counter
// after reset a clearing pass over max(SETS, SIG_ENTRIES) addresses (4096 by default)
//   sets every row to all-threes and every counter to four; s_tready stays low
// a victim item waits in execute while the output register is full and not taken;
//   an update item never waits
// the configuration channel is always ready
module ship_drrip_cache_replacement_core #(
	parameter int unsigned SETS        = sdrc_pkg::SETS_DEF,        // power of two
	parameter int unsigned WAYS        = sdrc_pkg::WAYS_DEF,
	parameter int unsigned SIG_ENTRIES = sdrc_pkg::SIG_ENTRIES_DEF  // power of two
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// [10:0] set_index, [14:11] way_index, [78:15] program_counter, [79] was_hit
	input  logic [sdrc_pkg::S_DATA_W-1:0]      s_tdata,
	// [0] operation
	input  logic                               s_tuser,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [3:0] victim_way, [7:4] zero
	output logic [sdrc_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [sdrc_pkg::THR_W-1:0]         cfg_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready
);

	// the clearing pass covers the larger of the two memories
	localparam int unsigned CLR_DEPTH = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
	localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

	sdrc_pkg::cmd_t                  cmd;
	sdrc_pkg::sts_t                  sts;
	logic [CLR_W-1:0]                clr_addr;
	logic [sdrc_pkg::WAY_IN_W-1:0]   victim_way;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {{(sdrc_pkg::M_DATA_W - sdrc_pkg::WAY_IN_W){1'b0}}, victim_way};

	sdrc_ctrl #(
		.CLR_DEPTH (CLR_DEPTH),
		.CLR_W     (CLR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	// unpack the item straight into the datapath
	sdrc_dpath #(
		.SETS        (SETS),
		.WAYS        (WAYS),
		.SIG_ENTRIES (SIG_ENTRIES),
		.CLR_W       (CLR_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.clr_addr   (clr_addr),
		.op_in      (s_tuser),
		.set_in     (s_tdata[10:0]),
		.way_in     (s_tdata[14:11]),
		.pc_in      (s_tdata[78:15]),
		.hit_in     (s_tdata[79]),
		.cfg_we     (cfg_valid),
		.cfg_thr    (cfg_data),
		.victim_way (victim_way)
	);

endmodule

FILE: rtl/sdrc_ctrl.sv
// controller: clearing pass, item sequencing and output register valid
module sdrc_ctrl #(
	parameter int unsigned CLR_DEPTH = sdrc_pkg::SIG_ENTRIES_DEF,
	parameter int unsigned CLR_W     = $clog2(CLR_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  sdrc_pkg::sts_t      sts,
	output sdrc_pkg::cmd_t      cmd,
	output logic [CLR_W-1:0]    clr_addr
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic             m_valid_q;
	logic             out_free;
	logic             go;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign clr_addr = clr_q;

	// a victim item waits in execute until the output register can take it
	assign go = (state_q == ST_EXEC) && (!sts.victim_req || out_free);

	always_comb begin
		cmd.fetch  = s_tvalid && (state_q == ST_IDLE);
		cmd.commit = go;
		cmd.clear  = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (go && sts.victim_req) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sdrc_dpath.sv
// datapath: set row memory, signature memory, victim search, insertion and training
module sdrc_dpath #(
	parameter int unsigned SETS        = sdrc_pkg::SETS_DEF,
	parameter int unsigned WAYS        = sdrc_pkg::WAYS_DEF,
	parameter int unsigned SIG_ENTRIES = sdrc_pkg::SIG_ENTRIES_DEF,
	parameter int unsigned CLR_W       = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sdrc_pkg::cmd_t                  cmd,
	output sdrc_pkg::sts_t                  sts,
	input  logic [CLR_W-1:0]                clr_addr,
	input  logic                            op_in,
	input  logic [sdrc_pkg::SET_IN_W-1:0]   set_in,
	input  logic [sdrc_pkg::WAY_IN_W-1:0]   way_in,
	input  logic [sdrc_pkg::PC_W-1:0]       pc_in,
	input  logic                            hit_in,
	input  logic                            cfg_we,
	input  logic [sdrc_pkg::THR_W-1:0]      cfg_thr,
	output logic [sdrc_pkg::WAY_IN_W-1:0]   victim_way
);

	localparam int unsigned SET_W = $clog2(SETS);
	localparam int unsigned SIG_W = $clog2(SIG_ENTRIES);
	localparam int unsigned WI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ROW_W = sdrc_pkg::RRPV_W * WAYS;

	logic [ROW_W-1:0]              rrpv_mem [SETS];
	logic [sdrc_pkg::SC_W-1:0]     sig_mem  [SIG_ENTRIES];

	// item registers
	logic                          op_q;
	logic [SET_W-1:0]              set_q;
	logic [sdrc_pkg::WAY_IN_W-1:0] way_q;
	logic [SIG_W-1:0]              sig_q;
	logic                          hit_q;
	logic [ROW_W-1:0]              row_q;
	logic [sdrc_pkg::SC_W-1:0]     sc_q;
	logic [sdrc_pkg::WAY_IN_W-1:0] victim_q;

	// training state
	logic [sdrc_pkg::SEL_W-1:0]    sel_q;
	logic [sdrc_pkg::BIM_W-1:0]    bim_q;
	logic [sdrc_pkg::THR_W-1:0]    thr_q;

	logic [31:0]                   set_ext;
	logic [SET_W-1:0]              set_idx;
	logic [sdrc_pkg::PC_W-1:0]     hash;
	logic [SIG_W-1:0]              sig_idx;

	logic                          any3, any_hi, any_lo;
	logic [sdrc_pkg::RRPV_W-1:0]   top, add;
	logic [WI_W-1:0]               victim;
	logic [ROW_W-1:0]              aged_row, upd_row, new_row;
	logic [sdrc_pkg::RRPV_W-1:0]   nv;
	logic                          bim_step;
	logic                          srrip_lead, brrip_lead;
	logic                          is_update;
	logic                          clr_set_ok, clr_sig_ok;
	logic [31:0]                   victim_ext;

	assign set_ext = 32'(set_in);
	assign set_idx = set_ext[SET_W-1:0];
	assign hash    = pc_in ^ (pc_in >> sdrc_pkg::HASH_SH1) ^ (pc_in >> sdrc_pkg::HASH_SH2);
	assign sig_idx = hash[SIG_W-1:0];

	assign is_update  = (op_q == sdrc_pkg::OP_UPDATE);
	assign srrip_lead = (set_q[5:0] == sdrc_pkg::LEAD_SRRIP);
	assign brrip_lead = (set_q[5:0] == sdrc_pkg::LEAD_BRRIP);
	assign sts.victim_req = !is_update;

	assign clr_set_ok = ({1'b0, clr_addr} < (CLR_W + 1)'(SETS));
	assign clr_sig_ok = ({1'b0, clr_addr} < (CLR_W + 1)'(SIG_ENTRIES));

	// highest value in the row, lowest way holding it, row aged up to the maximum
	always_comb begin
		any3   = 1'b0;
		any_hi = 1'b0;
		any_lo = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			any3   = any3 | (row_q[2*w +: 2] == sdrc_pkg::RRPV_MAX);
			any_hi = any_hi | row_q[2*w + 1];
			any_lo = any_lo | row_q[2*w];
		end
		if (any3) begin
			top = 2'd3;
		end else if (any_hi) begin
			top = 2'd2;
		end else if (any_lo) begin
			top = 2'd1;
		end else begin
			top = 2'd0;
		end
		add = sdrc_pkg::RRPV_MAX - top;
		victim = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_q[2*w +: 2] == top) begin
				victim = WI_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			aged_row[2*w +: 2] = row_q[2*w +: 2] + add;
		end
	end

	// insertion or promotion value
	always_comb begin
		bim_step = 1'b0;
		if (hit_q) begin
			nv = sdrc_pkg::RRPV_HOT;
		end else if (sc_q >= thr_q) begin
			nv = sdrc_pkg::RRPV_HOT;
		end else if (sc_q == sdrc_pkg::SIG_ZERO) begin
			nv = sdrc_pkg::RRPV_MAX;
		end else if (srrip_lead) begin
			nv = sdrc_pkg::RRPV_NEAR;
		end else if (brrip_lead) begin
			nv = sdrc_pkg::RRPV_MAX;
		end else if (sel_q > sdrc_pkg::SEL_MID) begin
			nv = sdrc_pkg::RRPV_NEAR;
		end else begin
			nv = (bim_q == sdrc_pkg::BIM_ZERO) ? sdrc_pkg::RRPV_NEAR : sdrc_pkg::RRPV_MAX;
			bim_step = 1'b1;
		end
		upd_row = row_q;
		for (int w = 0; w < WAYS; w++) begin
			if (32'(way_q) == 32'(w)) begin
				upd_row[2*w +: 2] = nv;
			end
		end
	end

	// a way beyond the set leaves the row as it was
	assign new_row = is_update ? upd_row : aged_row;

	// set row memory
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_set_ok) begin
				rrpv_mem[clr_addr[SET_W-1:0]] <= '1;
			end
		end else if (cmd.commit) begin
			rrpv_mem[set_q] <= new_row;
		end
		if (cmd.fetch) begin
			row_q <= rrpv_mem[set_idx];
		end
	end

	// signature memory
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_sig_ok) begin
				sig_mem[clr_addr[SIG_W-1:0]] <= sdrc_pkg::SIG_START;
			end
		end else if (cmd.commit && is_update && hit_q && (sc_q < sdrc_pkg::SIG_TOP)) begin
			sig_mem[sig_q] <= sc_q + 1'b1;
		end
		if (cmd.fetch) begin
			sc_q <= sig_mem[sig_idx];
		end
	end

	// item and result registers
	assign victim_ext = 32'(victim);
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			op_q  <= op_in;
			set_q <= set_idx;
			way_q <= way_in;
			sig_q <= sig_idx;
			hit_q <= hit_in;
		end
		if (cmd.commit && !is_update) begin
			victim_q <= victim_ext[sdrc_pkg::WAY_IN_W-1:0];
		end
	end
	assign victim_way = victim_q;

	// dueling selector, bimodal counter, threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= sdrc_pkg::SEL_MID;
			bim_q <= sdrc_pkg::BIM_ZERO;
			thr_q <= sdrc_pkg::THR_RESET;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_thr;
			end
			if (cmd.commit && is_update) begin
				if (hit_q) begin
					if (srrip_lead) begin
						if (sel_q < sdrc_pkg::SEL_TOP) begin
							sel_q <= sel_q + 1'b1;
						end
					end else if (brrip_lead) begin
						if (sel_q > sdrc_pkg::SEL_ZERO) begin
							sel_q <= sel_q - 1'b1;
						end
					end
				end else if (bim_step) begin
					bim_q <= bim_q + 1'b1;
				end
			end
		end
	end

endmodule
